// ----- hw/rtl/lpps_pkg.sv -----
// Package: widths, constants, codes and shared types of the line-position PD steering block
`default_nettype none
package lpps_pkg;

  localparam int GAIN_FRAC_BITS = 8;

  localparam int SAMPLE_W   = 10;
  localparam int SPEED_W    = 9;
  localparam int GAIN_W     = 12;
  localparam int LEVEL_W    = 10;
  localparam int POS_W      = 12;
  localparam int ERR_W      = 12;
  localparam int VSUM_W     = 12;
  localparam int DIVD_W     = 23;
  localparam int MUL_A_W    = 13;
  localparam int ACC_W      = 26;
  localparam int DIFF_W     = ACC_W - GAIN_FRAC_BITS;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_CNT_W  = $clog2(DIVD_W);

  localparam logic [POS_W-1:0] LINE_CENTRE = 12'd2000;
  localparam logic [POS_W-1:0] LINE_MAX    = 12'd4000;

  localparam logic [SPEED_W-1:0] BASE_SPEED_RST     = 9'd200;
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST      = 12'd102;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST     = 12'd384;
  localparam logic [LEVEL_W-1:0] PRESENCE_LEVEL_RST = 10'd200;
  localparam logic [LEVEL_W-1:0] NOISE_LEVEL_RST    = 10'd50;
  localparam logic [LEVEL_W-1:0] CROSSING_LEVEL_RST = 10'd700;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_SPEED     = 3'd0,
    CFG_PROP_GAIN      = 3'd1,
    CFG_DERIV_GAIN     = 3'd2,
    CFG_PRESENCE_LEVEL = 3'd3,
    CFG_NOISE_LEVEL    = 3'd4,
    CFG_CROSSING_LEVEL = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENT,
    ST_DIV,
    ST_MAC,
    ST_SPEED,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [VSUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [GAIN_W-1:0] centroid_weight(input logic [1:0] idx);
    logic [GAIN_W-1:0] w;
    case (idx)
      2'd0:    w = 12'd1000;
      2'd1:    w = 12'd2000;
      default: w = 12'd3000;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/lpps_if.sv -----
// Interfaces: sensor transaction channel and wheel speed transaction channel
`default_nettype none
interface lpps_in_if;
  logic                          valid;
  logic                          ready;
  logic [lpps_pkg::SAMPLE_W-1:0] sensor_0;
  logic [lpps_pkg::SAMPLE_W-1:0] sensor_1;
  logic [lpps_pkg::SAMPLE_W-1:0] sensor_2;
  logic [lpps_pkg::SAMPLE_W-1:0] sensor_3;
  logic [lpps_pkg::SAMPLE_W-1:0] sensor_4;

  modport source (output valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4,
                  input ready);
  modport sink   (input valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4,
                  output ready);
endinterface

interface lpps_out_if;
  logic                         valid;
  logic                         ready;
  logic [lpps_pkg::SPEED_W-1:0] left_speed;
  logic [lpps_pkg::SPEED_W-1:0] right_speed;
  logic                         at_crossing;

  modport source (output valid, left_speed, right_speed, at_crossing, input ready);
  modport sink   (input valid, left_speed, right_speed, at_crossing, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/line_position_pd_steering_top.sv -----
// Top level: weighted-centroid line position and PD wheel steering on a shared MAC
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  in_chan  | in  | valid/ready        | sensor_0 .. sensor_4 (10 b each)
//  out_chan | out | valid/ready        | left_speed, right_speed (9 b), at_crossing
//  cfg_*    | in  | cfg_we, no wait    | cfg_index (3 b), cfg_wdata (12 b)
//
// Each transaction runs the 23-step serial divider; a crossing skips the PD multiply and speed steps.
// One shared multiply-accumulate serves three centroid terms and two PD terms.
// in_chan.ready is high only while idle; the result register frees the input
// side, a new transaction finishes only once the previous result has left.
// Synchronous active-low reset; clears control, last position and last error.
`default_nettype none
module line_position_pd_steering_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  lpps_in_if.sink                             in_chan,
  lpps_out_if.source                          out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [lpps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lpps_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SW = lpps_pkg::SAMPLE_W;

  lpps_pkg::state_t state_r, state_nxt;

  logic [lpps_pkg::SPEED_W-1:0] base_speed_r;
  logic [lpps_pkg::GAIN_W-1:0]  prop_gain_r, deriv_gain_r;
  logic [lpps_pkg::LEVEL_W-1:0] presence_level_r, noise_level_r, crossing_level_r;

  logic [SW-1:0]                  samp_r [3];
  logic [SW-1:0]                  samp_nxt [3];
  logic                           seen_r, seen_nxt;
  logic                           cross_r, cross_nxt;
  logic [1:0]                     step_r, step_nxt;
  logic signed [lpps_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [lpps_pkg::VSUM_W-1:0]    vsum_r, vsum_nxt;
  logic [lpps_pkg::POS_W-1:0]     last_pos_r, last_pos_nxt;
  logic signed [lpps_pkg::ERR_W-1:0] last_err_r, last_err_nxt;
  logic signed [lpps_pkg::ERR_W-1:0] err_r, err_nxt;
  logic [lpps_pkg::SPEED_W-1:0]   res_left_r, res_left_nxt;
  logic [lpps_pkg::SPEED_W-1:0]   res_right_r, res_right_nxt;
  logic                           res_cross_r, res_cross_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [lpps_pkg::SPEED_W-1:0]   out_left_r, out_right_r;
  logic                           out_cross_r;
  logic                           out_load;

  logic signed [lpps_pkg::MUL_A_W-1:0] mul_a;
  logic [lpps_pkg::GAIN_W-1:0]         mul_b;
  logic signed [lpps_pkg::ACC_W-1:0]   prod;

  logic [lpps_pkg::POS_W-1:0]     pos;
  logic [lpps_pkg::ACC_W-1:0]     mag;
  logic [lpps_pkg::DIFF_W-1:0]    diff;
  logic [lpps_pkg::DIFF_W-1:0]    top_ext;
  logic [lpps_pkg::DIFF_W-1:0]    slow_full;
  logic [lpps_pkg::SPEED_W-1:0]   slow;

  lpps_pkg::div_req_t div_req;
  lpps_pkg::div_rsp_t div_rsp;

  lpps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign prod = mul_a * $signed({1'b0, mul_b});

  assign mag       = acc_r[lpps_pkg::ACC_W-1] ? lpps_pkg::ACC_W'(-acc_r)
                                              : lpps_pkg::ACC_W'(acc_r);
  assign diff      = mag[lpps_pkg::ACC_W-1:lpps_pkg::GAIN_FRAC_BITS];
  assign top_ext   = lpps_pkg::DIFF_W'(base_speed_r);
  assign slow_full = top_ext - diff;
  assign slow      = (diff >= top_ext) ? '0 : slow_full[lpps_pkg::SPEED_W-1:0];

  assign in_chan.ready = (state_r == lpps_pkg::ST_IDLE);
  assign out_load      = (state_r == lpps_pkg::ST_FIN) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt     = state_r;
    samp_nxt      = samp_r;
    seen_nxt      = seen_r;
    cross_nxt     = cross_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    vsum_nxt      = vsum_r;
    last_pos_nxt  = last_pos_r;
    last_err_nxt  = last_err_r;
    err_nxt       = err_r;
    res_left_nxt  = res_left_r;
    res_right_nxt = res_right_r;
    res_cross_nxt = res_cross_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    mul_a         = '0;
    mul_b         = '0;
    pos           = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;

    case (state_r)
      lpps_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          samp_nxt[0] = (in_chan.sensor_1 > noise_level_r) ? in_chan.sensor_1 : '0;
          samp_nxt[1] = (in_chan.sensor_2 > noise_level_r) ? in_chan.sensor_2 : '0;
          samp_nxt[2] = (in_chan.sensor_3 > noise_level_r) ? in_chan.sensor_3 : '0;
          seen_nxt    = (in_chan.sensor_1 > presence_level_r) ||
                        (in_chan.sensor_2 > presence_level_r) ||
                        (in_chan.sensor_3 > presence_level_r);
          cross_nxt   = (in_chan.sensor_0 > crossing_level_r) ||
                        (in_chan.sensor_4 > crossing_level_r);
          acc_nxt     = '0;
          vsum_nxt    = '0;
          step_nxt    = '0;
          state_nxt   = lpps_pkg::ST_CENT;
        end
      end
      lpps_pkg::ST_CENT: begin
        mul_a    = $signed({{(lpps_pkg::MUL_A_W-SW){1'b0}}, samp_r[step_r]});
        mul_b    = lpps_pkg::centroid_weight(step_r);
        acc_nxt  = acc_r + prod;
        vsum_nxt = vsum_r + lpps_pkg::VSUM_W'(samp_r[step_r]);
        step_nxt = step_r + 1'b1;
        if (step_r == 2'd2) begin
          div_req.start    = 1'b1;
          div_req.dividend = acc_nxt[lpps_pkg::DIVD_W-1:0];
          div_req.divisor  = vsum_nxt;
          state_nxt        = lpps_pkg::ST_DIV;
        end
      end
      lpps_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (!seen_r) begin
            pos = (last_pos_r < lpps_pkg::LINE_CENTRE) ? '0 : lpps_pkg::LINE_MAX;
          end else if (vsum_r == '0) begin
            pos = last_pos_r;
          end else begin
            pos          = div_rsp.quotient[lpps_pkg::POS_W-1:0];
            last_pos_nxt = pos;
          end
          err_nxt = $signed(pos - lpps_pkg::LINE_CENTRE);
          if (cross_r) begin
            res_left_nxt  = '0;
            res_right_nxt = '0;
            res_cross_nxt = 1'b1;
            state_nxt     = lpps_pkg::ST_FIN;
          end else begin
            acc_nxt   = '0;
            step_nxt  = '0;
            state_nxt = lpps_pkg::ST_MAC;
          end
        end
      end
      lpps_pkg::ST_MAC: begin
        if (step_r == 2'd0) begin
          mul_a = lpps_pkg::MUL_A_W'(err_r);
          mul_b = prop_gain_r;
        end else begin
          mul_a = lpps_pkg::MUL_A_W'(err_r) - lpps_pkg::MUL_A_W'(last_err_r);
          mul_b = deriv_gain_r;
          state_nxt = lpps_pkg::ST_SPEED;
        end
        acc_nxt  = acc_r + prod;
        step_nxt = step_r + 1'b1;
      end
      lpps_pkg::ST_SPEED: begin
        last_err_nxt  = err_r;
        res_cross_nxt = 1'b0;
        if (acc_r[lpps_pkg::ACC_W-1]) begin
          res_left_nxt  = slow;
          res_right_nxt = base_speed_r;
        end else begin
          res_left_nxt  = base_speed_r;
          res_right_nxt = slow;
        end
        state_nxt = lpps_pkg::ST_FIN;
      end
      lpps_pkg::ST_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = lpps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lpps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      last_pos_r  <= '0;
      last_err_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_pos_r  <= last_pos_nxt;
      last_err_r  <= last_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_speed_r     <= lpps_pkg::BASE_SPEED_RST;
      prop_gain_r      <= lpps_pkg::PROP_GAIN_RST;
      deriv_gain_r     <= lpps_pkg::DERIV_GAIN_RST;
      presence_level_r <= lpps_pkg::PRESENCE_LEVEL_RST;
      noise_level_r    <= lpps_pkg::NOISE_LEVEL_RST;
      crossing_level_r <= lpps_pkg::CROSSING_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lpps_pkg::CFG_BASE_SPEED:     base_speed_r     <= cfg_wdata[lpps_pkg::SPEED_W-1:0];
        lpps_pkg::CFG_PROP_GAIN:      prop_gain_r      <= cfg_wdata[lpps_pkg::GAIN_W-1:0];
        lpps_pkg::CFG_DERIV_GAIN:     deriv_gain_r     <= cfg_wdata[lpps_pkg::GAIN_W-1:0];
        lpps_pkg::CFG_PRESENCE_LEVEL: presence_level_r <= cfg_wdata[lpps_pkg::LEVEL_W-1:0];
        lpps_pkg::CFG_NOISE_LEVEL:    noise_level_r    <= cfg_wdata[lpps_pkg::LEVEL_W-1:0];
        lpps_pkg::CFG_CROSSING_LEVEL: crossing_level_r <= cfg_wdata[lpps_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    samp_r      <= samp_nxt;
    seen_r      <= seen_nxt;
    cross_r     <= cross_nxt;
    step_r      <= step_nxt;
    acc_r       <= acc_nxt;
    vsum_r      <= vsum_nxt;
    err_r       <= err_nxt;
    res_left_r  <= res_left_nxt;
    res_right_r <= res_right_nxt;
    res_cross_r <= res_cross_nxt;
    if (out_load) begin
      out_left_r  <= res_left_r;
      out_right_r <= res_right_r;
      out_cross_r <= res_cross_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.left_speed  = out_left_r;
  assign out_chan.right_speed = out_right_r;
  assign out_chan.at_crossing = out_cross_r;

endmodule
`default_nettype wire

// ----- hw/rtl/lpps_div.sv -----
// Serial restoring divider, one quotient bit per cycle
`default_nettype none
module lpps_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lpps_pkg::div_req_t req,
  output lpps_pkg::div_rsp_t      rsp
);

  localparam logic [lpps_pkg::DIV_CNT_W-1:0] CNT_LAST =
    lpps_pkg::DIV_CNT_W'(lpps_pkg::DIVD_W - 1);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [lpps_pkg::DIV_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [lpps_pkg::VSUM_W-1:0]         rem_r, rem_nxt;
  logic [lpps_pkg::DIVD_W-1:0]         quo_r, quo_nxt;
  logic [lpps_pkg::VSUM_W-1:0]         dvs_r, dvs_nxt;
  logic [lpps_pkg::VSUM_W:0]           trial;
  logic [lpps_pkg::VSUM_W:0]           trial_sub;
  logic                                ge;

  assign trial     = {rem_r, quo_r[lpps_pkg::DIVD_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign ge        = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? trial_sub[lpps_pkg::VSUM_W-1:0] : trial[lpps_pkg::VSUM_W-1:0];
      quo_nxt = {quo_r[lpps_pkg::DIVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

// ----- hw/rtl/lpps_chk.sv -----
// Port-level checker for the steering block, bound to the top level
`default_nettype none
module lpps_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [lpps_pkg::SPEED_W-1:0] left_speed,
  input wire logic [lpps_pkg::SPEED_W-1:0] right_speed,
  input wire logic                         at_crossing
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready again right after a transaction was taken");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared one cycle after a transaction");

  a_crossing_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && at_crossing) |-> (left_speed == '0 && right_speed == '0))
    else $error("non-zero speed on a crossing");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(left_speed) && $stable(right_speed) && $stable(at_crossing)))
    else $error("stalled result changed");

endmodule

bind line_position_pd_steering_top lpps_chk u_lpps_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .left_speed  (out_chan.left_speed),
  .right_speed (out_chan.right_speed),
  .at_crossing (out_chan.at_crossing)
);
`default_nettype wire

// ----- tb/tb_line_position_pd_steering_top.sv -----
// Testbench: line position PD steering block, sensor frames checked against a local predictor
module tb_line_position_pd_steering_top;
  import lpps_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sensor_0;
    logic [SAMPLE_W-1:0] sensor_1;
    logic [SAMPLE_W-1:0] sensor_2;
    logic [SAMPLE_W-1:0] sensor_3;
    logic [SAMPLE_W-1:0] sensor_4;
  } sensor_frame_t;

  typedef struct packed {
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
    logic               at_crossing;
  } wheel_cmd_t;

  typedef struct packed {
    sensor_frame_t frame;
    logic          has_cmd;
    wheel_cmd_t    cmd;
  } directed_row_t;

  typedef struct packed {
    logic [SPEED_W-1:0] base_speed;
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [LEVEL_W-1:0] presence_level;
    logic [LEVEL_W-1:0] noise_level;
    logic [LEVEL_W-1:0] crossing_level;
  } steer_settings_t;

  typedef struct {
    wheel_cmd_t cmd;
    int         item;
  } steer_expect_t;

  localparam int PHASES     = 9;
  localparam int PHASE_ITEMS = 195;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lpps_in_if  in_if ();
  lpps_out_if out_if ();

  line_position_pd_steering_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor copy of the block's settings and state
  steer_settings_t          steer_cfg;
  logic [POS_W-1:0]         held_position;
  logic signed [ERR_W-1:0]  held_error;

  steer_expect_t pending_cmds [$];
  int  mismatch_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  bit  steady_flow = 1'b0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH %s", what);
    mismatch_count++;
  endtask

  function automatic int speed_clamp(input int v, input int top);
    if (v < 0) return 0;
    if (v > top) return top;
    return v;
  endfunction

  function automatic wheel_cmd_t steer_predict(input sensor_frame_t f);
    int mid [3];
    int wsum, vsum, pos, err, acc, mag, diff, top, pg, dg, prev_err;
    bit seen;
    wheel_cmd_t cmd;
    mid[0] = int'(f.sensor_1);
    mid[1] = int'(f.sensor_2);
    mid[2] = int'(f.sensor_3);
    seen = 1'b0;
    wsum = 0;
    vsum = 0;
    for (int i = 0; i < 3; i++) begin
      if (mid[i] > int'(steer_cfg.presence_level)) seen = 1'b1;
      if (mid[i] > int'(steer_cfg.noise_level)) begin
        wsum += mid[i] * (i + 1) * 1000;
        vsum += mid[i];
      end
    end
    if (!seen) begin
      pos = (held_position < LINE_CENTRE) ? 0 : int'(LINE_MAX);
    end else if (vsum == 0) begin
      pos = int'(held_position);
    end else begin
      pos = wsum / vsum;
      held_position = pos[POS_W-1:0];
    end
    if (f.sensor_0 > steer_cfg.crossing_level || f.sensor_4 > steer_cfg.crossing_level) begin
      cmd.left_speed  = '0;
      cmd.right_speed = '0;
      cmd.at_crossing = 1'b1;
      return cmd;
    end
    pg = int'(steer_cfg.prop_gain);
    dg = int'(steer_cfg.deriv_gain);
    prev_err = int'(held_error);
    err = pos - int'(LINE_CENTRE);
    acc = pg * err + dg * (err - prev_err);
    mag = (acc < 0) ? -acc : acc;
    diff = mag >> GAIN_FRAC_BITS;
    if (acc < 0) diff = -diff;
    held_error = err[ERR_W-1:0];
    top = int'(steer_cfg.base_speed);
    cmd.left_speed  = SPEED_W'(speed_clamp(top + diff, top));
    cmd.right_speed = SPEED_W'(speed_clamp(top - diff, top));
    cmd.at_crossing = 1'b0;
    return cmd;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 96) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int level);
    int v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = 1000;
      2, 3:    v = level + int'($urandom_range(0, 6)) - 3;
      default: v = $urandom_range(0, 1000);
    endcase
    if (v < 0) v = 0;
    if (v > 1000) v = 1000;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic sensor_frame_t random_frame();
    sensor_frame_t f;
    int quiet_top;
    int side;
    if ($urandom_range(0, 7) == 0) begin
      // everything at or below the noise floor: lost line or empty centroid
      quiet_top = int'(steer_cfg.noise_level);
      f.sensor_1 = SAMPLE_W'($urandom_range(0, quiet_top));
      f.sensor_2 = SAMPLE_W'($urandom_range(0, quiet_top));
      f.sensor_3 = SAMPLE_W'($urandom_range(0, quiet_top));
    end else begin
      f.sensor_1 = pick_sample($urandom_range(0, 1) ? int'(steer_cfg.presence_level)
                                                    : int'(steer_cfg.noise_level));
      f.sensor_2 = pick_sample($urandom_range(0, 1) ? int'(steer_cfg.presence_level)
                                                    : int'(steer_cfg.noise_level));
      f.sensor_3 = pick_sample($urandom_range(0, 1) ? int'(steer_cfg.presence_level)
                                                    : int'(steer_cfg.noise_level));
    end
    f.sensor_0 = SAMPLE_W'($urandom_range(0, steer_cfg.crossing_level));
    f.sensor_4 = SAMPLE_W'($urandom_range(0, steer_cfg.crossing_level));
    if ($urandom_range(0, 5) == 0) begin
      side = $urandom_range(0, 2);
      if (side != 1) f.sensor_0 = pick_sample(int'(steer_cfg.crossing_level));
      if (side != 0) f.sensor_4 = pick_sample(int'(steer_cfg.crossing_level));
    end
    return f;
  endfunction

  function automatic steer_settings_t settings_for(input int phase);
    steer_settings_t s;
    case (phase)
      1: s = '{9'd400, 12'd4095, 12'd4095, 10'd0, 10'd0, 10'd1000};
      2: s = '{9'd0, 12'd0, 12'd0, 10'd1000, 10'd1000, 10'd0};
      3: s = '{9'd200, 12'd102, 12'd384, 10'd100, 10'd500, 10'd700};
      4: s = '{9'd400, 12'd4095, 12'd0, 10'd0, 10'd1000, 10'd1000};
      default: begin
        s.base_speed     = SPEED_W'($urandom_range(0, 400));
        s.prop_gain      = GAIN_W'($urandom_range(0, 4095));
        s.deriv_gain     = GAIN_W'($urandom_range(0, 4095));
        s.presence_level = LEVEL_W'($urandom_range(0, 1000));
        s.noise_level    = LEVEL_W'($urandom_range(0, 1000));
        s.crossing_level = LEVEL_W'($urandom_range(0, 1000));
      end
    endcase
    return s;
  endfunction

  function automatic directed_row_t mk_row(input int s0, s1, s2, s3, s4,
                                           input bit has_cmd = 1'b0,
                                           input int lft = 0, rgt = 0,
                                           input bit crossing_flag = 1'b0);
    directed_row_t r;
    r.frame = '{s0[SAMPLE_W-1:0], s1[SAMPLE_W-1:0], s2[SAMPLE_W-1:0],
                s3[SAMPLE_W-1:0], s4[SAMPLE_W-1:0]};
    r.has_cmd = has_cmd;
    r.cmd = '{lft[SPEED_W-1:0], rgt[SPEED_W-1:0], crossing_flag};
    return r;
  endfunction

  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input steer_settings_t s);
    put_reg(CFG_BASE_SPEED, CFG_DATA_W'(s.base_speed));
    put_reg(CFG_PROP_GAIN, s.prop_gain);
    put_reg(CFG_DERIV_GAIN, s.deriv_gain);
    put_reg(CFG_PRESENCE_LEVEL, CFG_DATA_W'(s.presence_level));
    put_reg(CFG_NOISE_LEVEL, CFG_DATA_W'(s.noise_level));
    put_reg(CFG_CROSSING_LEVEL, CFG_DATA_W'(s.crossing_level));
    cfg_we <= 1'b0;
    steer_cfg = s;
  endtask

  task automatic send_frame(input sensor_frame_t f, input bit has_cmd,
                            input wheel_cmd_t typed_cmd);
    int gap;
    steer_expect_t e;
    wheel_cmd_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.sensor_0 <= f.sensor_0;
    in_if.sensor_1 <= f.sensor_1;
    in_if.sensor_2 <= f.sensor_2;
    in_if.sensor_3 <= f.sensor_3;
    in_if.sensor_4 <= f.sensor_4;
    do @(posedge clk); while (!in_if.ready);
    pred = steer_predict(f);
    e.cmd  = has_cmd ? typed_cmd : pred;
    e.item = items_sent;
    pending_cmds.push_back(e);
    items_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_cmds.size() != 0 || !in_if.ready) @(posedge clk);
  endtask

  initial begin : stimulus
    directed_row_t directed_rows [$];
    int n_random;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.sensor_0 = '0;
    in_if.sensor_1 = '0;
    in_if.sensor_2 = '0;
    in_if.sensor_3 = '0;
    in_if.sensor_4 = '0;
    steer_cfg = '{BASE_SPEED_RST, PROP_GAIN_RST, DERIV_GAIN_RST,
                  PRESENCE_LEVEL_RST, NOISE_LEVEL_RST, CROSSING_LEVEL_RST};
    held_position = '0;
    held_error    = '0;

    // reset settings; sample order s0..s4
    directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 1, 0, 200, 0));
    directed_rows.push_back(mk_row(1000, 0, 0, 0, 0, 1, 0, 0, 1));
    directed_rows.push_back(mk_row(0, 0, 0, 0, 1000, 1, 0, 0, 1));
    directed_rows.push_back(mk_row(701, 0, 1000, 0, 0, 1, 0, 0, 1));
    directed_rows.push_back(mk_row(0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(700, 0, 1000, 0, 700));
    directed_rows.push_back(mk_row(0, 1000, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 0, 0, 1000, 0));
    directed_rows.push_back(mk_row(0, 1000, 1000, 1000, 0));
    directed_rows.push_back(mk_row(0, 201, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 200, 200, 200, 0));
    directed_rows.push_back(mk_row(0, 51, 51, 201, 0));
    directed_rows.push_back(mk_row(0, 50, 1000, 50, 0));
    directed_rows.push_back(mk_row(0, 1000, 1000, 0, 0));
    directed_rows.push_back(mk_row(0, 0, 1000, 1000, 0));
    directed_rows.push_back(mk_row(1000, 1000, 0, 0, 1000, 1, 0, 0, 1));
    directed_rows.push_back(mk_row(0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 0, 0, 1000, 0));
    directed_rows.push_back(mk_row(0, 1000, 0, 0, 0));
    directed_rows.push_back(mk_row(511, 512, 1, 1000, 511));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_frame(directed_rows[i].frame, directed_rows[i].has_cmd, directed_rows[i].cmd);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        load_settings(settings_for(phase));
      end
      steady_flow = (phase == 2 || phase == 5);
      n_random = (phase == 0) ? PHASE_ITEMS - directed_rows.size() : PHASE_ITEMS;
      repeat (n_random) send_frame(random_frame(), 1'b0, '0);
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_cmds.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : wheel_sink
    steer_expect_t e;
    int  stall_left;
    int  g;
    bit  pressure_done;
    out_if.ready  = 1'b0;
    stall_left    = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_cmds.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction: left %0d right %0d crossing %0b",
                                    out_if.left_speed, out_if.right_speed,
                                    out_if.at_crossing));
        end else begin
          e = pending_cmds.pop_front();
          if (out_if.left_speed !== e.cmd.left_speed)
            report_mismatch($sformatf("item %0d left_speed %0d, want %0d", e.item,
                                      out_if.left_speed, e.cmd.left_speed));
          if (out_if.right_speed !== e.cmd.right_speed)
            report_mismatch($sformatf("item %0d right_speed %0d, want %0d", e.item,
                                      out_if.right_speed, e.cmd.right_speed));
          if (out_if.at_crossing !== e.cmd.at_crossing)
            report_mismatch($sformatf("item %0d at_crossing %0b, want %0b", e.item,
                                      out_if.at_crossing, e.cmd.at_crossing));
        end
        results_seen++;
      end
      // long hold-off so the block backs up onto its input
      if (!pressure_done && results_seen >= 500) begin
        pressure_done = 1'b1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        g = pick_gap();
        out_if.ready <= (g == 0);
        if (g > 0) stall_left = g - 1;
      end
    end
  end

  initial begin : watchdog
    #(64'd15_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
